// ===== hdl/uep0_pkg.sv =====
package uep0_pkg;

	// field widths
	localparam int unsigned SRC_W    = 3;
	localparam int unsigned OFFSET_W = 10;
	localparam int unsigned PKTLEN_W = 7;
	localparam int unsigned ADDR_W   = 7;
	localparam int unsigned WORD_W   = 16;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 10;

	// largest control packet in bytes
	localparam logic [PKTLEN_W-1:0] MAX_PACKET_BYTES = 7'd64;

	// operation codes
	localparam logic OP_SETUP   = 1'b0;
	localparam logic OP_IN_DONE = 1'b1;

	// reply sources
	localparam logic [SRC_W-1:0] SRC_DEVICE       = 3'd0;
	localparam logic [SRC_W-1:0] SRC_CONFIG       = 3'd1;
	localparam logic [SRC_W-1:0] SRC_LANGUAGE     = 3'd2;
	localparam logic [SRC_W-1:0] SRC_MANUFACTURER = 3'd3;
	localparam logic [SRC_W-1:0] SRC_PRODUCT      = 3'd4;
	localparam logic [SRC_W-1:0] SRC_SERIAL       = 3'd5;
	localparam logic [SRC_W-1:0] SRC_LINE_CODING  = 3'd6;
	localparam logic [SRC_W-1:0] SRC_NONE         = 3'd7;

	// request type field (bits 6:5 of bmRequestType)
	localparam logic [1:0] KIND_STANDARD = 2'd0;
	localparam logic [1:0] KIND_CLASS    = 2'd1;

	// request codes
	localparam logic [7:0] REQ_SET_ADDRESS            = 8'h05;
	localparam logic [7:0] REQ_GET_DESCRIPTOR         = 8'h06;
	localparam logic [7:0] REQ_SET_CONFIGURATION      = 8'h09;
	localparam logic [7:0] REQ_SET_IDLE               = 8'h0A;
	localparam logic [7:0] REQ_SERIAL_STATE           = 8'h20;
	localparam logic [7:0] REQ_GET_LINE_CODING        = 8'h21;
	localparam logic [7:0] REQ_SET_CONTROL_LINE_STATE = 8'h22;

	// descriptor types
	localparam logic [7:0] DESC_DEVICE = 8'h01;
	localparam logic [7:0] DESC_CONFIG = 8'h02;
	localparam logic [7:0] DESC_STRING = 8'h03;
	localparam logic [7:0] DESC_REPORT = 8'h22;

	// string indexes
	localparam logic [7:0] STR_LANGUAGE     = 8'd0;
	localparam logic [7:0] STR_MANUFACTURER = 8'd1;
	localparam logic [7:0] STR_PRODUCT      = 8'd2;
	localparam logic [7:0] STR_SERIAL       = 8'd3;

	localparam logic [2:0] LINE_CODING_LEN = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PACKET_CODE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_LEN       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIG_TOTAL_LEN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LANGUAGE_LEN     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MANUFACTURER_LEN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PRODUCT_LEN      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SERIAL_LEN       = 3'd6;

endpackage

// ===== hdl/usb_ep0_control_responder.sv =====
// Control endpoint zero responder.
// Input channel (in_valid / in_stall) carries either a decoded setup request
// (op = setup) or an IN-complete event (op = in done). A transfer happens at a
// rising edge with valid high and stall low. Each input item yields zero or one
// result on the output channel (out_valid / out_stall): the reply source, byte
// offset and length of the next packet, plus the address and endpoint-enable
// side outputs of SET_ADDRESS and SET_CONFIGURATION.
// A transferred item sits in the input register, is decoded and answered
// there, and its result is then loaded into the result register.
// Throughput is one item per cycle while the receiver takes results; the
// cycle time is set by the decode, the 16-bit wLength clamp and the
// remaining-length compare and subtract.
// When the receiver stalls, the result register holds, the input register
// holds its item and in_stall rises; items without a result wait the same way.
// Configuration is written via cfg_write / cfg_index / cfg_data, by the user
// only while no transfer is in flight (unchecked); unknown indexes ignored.
// Reset clears all transfer state, loads the register defaults (packet code 1,
// lengths 18, 67, 4, 18, 56, 22) and empties both stages.
module usb_ep0_control_responder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration port
	input  logic                                 cfg_write,
	input  logic [uep0_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [uep0_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input channel
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 op,
	input  logic [7:0]                           request_type,
	input  logic [7:0]                           request_code,
	input  logic [uep0_pkg::WORD_W-1:0]          request_value,
	input  logic [uep0_pkg::WORD_W-1:0]          request_index,
	input  logic [uep0_pkg::WORD_W-1:0]          request_length,
	// output channel
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [uep0_pkg::SRC_W-1:0]           packet_source,
	output logic [uep0_pkg::OFFSET_W-1:0]        packet_offset,
	output logic [uep0_pkg::PKTLEN_W-1:0]        packet_length,
	output logic                                 address_write,
	output logic [uep0_pkg::ADDR_W-1:0]          new_address,
	output logic                                 endpoints_write,
	output logic                                 endpoints_enable
);

	// configuration registers
	logic [1:0] max_packet_code_q;
	logic [7:0] device_len_q;
	logic [9:0] config_total_len_q;
	logic [7:0] language_len_q;
	logic [7:0] manufacturer_len_q;
	logic [7:0] product_len_q;
	logic [7:0] serial_len_q;

	// transfer state
	logic [uep0_pkg::WORD_W-1:0]   remaining_q;
	logic [uep0_pkg::OFFSET_W-1:0] offset_q;
	logic [uep0_pkg::SRC_W-1:0]    source_q;
	logic                          zlp_pending_q;
	logic [7:0]                    config_value_q;

	// input stage
	logic                          valid_s1;
	logic                          op_s1;
	logic [7:0]                    rtype_s1;
	logic [7:0]                    code_s1;
	logic [uep0_pkg::WORD_W-1:0]   wvalue_s1;
	logic [uep0_pkg::WORD_W-1:0]   windex_s1;
	logic [uep0_pkg::WORD_W-1:0]   wlength_s1;

	// result register
	logic                          out_valid_q;
	logic [uep0_pkg::SRC_W-1:0]    src_q;
	logic [uep0_pkg::OFFSET_W-1:0] off_q;
	logic [uep0_pkg::PKTLEN_W-1:0] len_q;
	logic                          addr_w_q;
	logic [uep0_pkg::ADDR_W-1:0]   addr_q;
	logic                          ep_w_q;
	logic                          ep_en_q;

	logic out_ready;
	logic advance;

	// decode signals
	logic                          is_setup;
	logic [1:0]                    kind;
	logic [7:0]                    dtype;
	logic [7:0]                    dindex;
	logic                          clamp_en;
	logic [uep0_pkg::SRC_W-1:0]    clamp_src;
	logic [9:0]                    clamp_len;
	logic                          status_en;
	logic                          lc_en;
	logic                          addr_w;
	logic                          ep_w;
	logic                          go;

	// packet size
	logic [uep0_pkg::PKTLEN_W-1:0] pkt_size;
	logic [uep0_pkg::PKTLEN_W-1:0] pkt_mask;

	// armed state ahead of sending
	logic [uep0_pkg::WORD_W-1:0]   arm_rem;
	logic [uep0_pkg::OFFSET_W-1:0] arm_off;
	logic [uep0_pkg::SRC_W-1:0]    arm_src;
	logic                          arm_zlp;
	logic [2:0]                    lc_len;

	// state after sending
	logic [uep0_pkg::WORD_W-1:0]   nxt_rem;
	logic [uep0_pkg::OFFSET_W-1:0] nxt_off;
	logic                          nxt_zlp;
	logic [uep0_pkg::PKTLEN_W-1:0] send_len;
	logic                          send_ok;
	logic                          result;

	assign out_ready = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_packet_code_q  <= 2'd1;
			device_len_q       <= 8'd18;
			config_total_len_q <= 10'd67;
			language_len_q     <= 8'd4;
			manufacturer_len_q <= 8'd18;
			product_len_q      <= 8'd56;
			serial_len_q       <= 8'd22;
		end else if (cfg_write) begin
			unique case (cfg_index)
				uep0_pkg::REG_MAX_PACKET_CODE:  max_packet_code_q  <= cfg_data[1:0];
				uep0_pkg::REG_DEVICE_LEN:       device_len_q       <= cfg_data[7:0];
				uep0_pkg::REG_CONFIG_TOTAL_LEN: config_total_len_q <= cfg_data[9:0];
				uep0_pkg::REG_LANGUAGE_LEN:     language_len_q     <= cfg_data[7:0];
				uep0_pkg::REG_MANUFACTURER_LEN: manufacturer_len_q <= cfg_data[7:0];
				uep0_pkg::REG_PRODUCT_LEN:      product_len_q      <= cfg_data[7:0];
				uep0_pkg::REG_SERIAL_LEN:       serial_len_q       <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// capture input item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1      <= op;
			rtype_s1   <= request_type;
			code_s1    <= request_code;
			wvalue_s1  <= request_value;
			windex_s1  <= request_index;
			wlength_s1 <= request_length;
		end
	end

	assign pkt_size = uep0_pkg::PKTLEN_W'(7'd8 << max_packet_code_q);
	assign pkt_mask = pkt_size - 7'd1;

	assign is_setup = (op_s1 == uep0_pkg::OP_SETUP);
	assign kind     = rtype_s1[6:5];
	assign dtype    = wvalue_s1[15:8];
	assign dindex   = wvalue_s1[7:0];

	// decode setup request
	always_comb begin
		clamp_en  = 1'b0;
		clamp_src = uep0_pkg::SRC_NONE;
		clamp_len = 10'd0;
		status_en = 1'b0;
		lc_en     = 1'b0;
		addr_w    = 1'b0;
		ep_w      = 1'b0;
		if (rtype_s1[7]) begin
			priority if (kind == uep0_pkg::KIND_STANDARD &&
			             code_s1 == uep0_pkg::REQ_GET_DESCRIPTOR) begin
				priority if (dtype == uep0_pkg::DESC_DEVICE) begin
					clamp_en  = 1'b1;
					clamp_src = uep0_pkg::SRC_DEVICE;
					clamp_len = {2'd0, device_len_q};
				end else if (dtype == uep0_pkg::DESC_CONFIG) begin
					clamp_en  = 1'b1;
					clamp_src = uep0_pkg::SRC_CONFIG;
					clamp_len = config_total_len_q;
				end else if (dtype == uep0_pkg::DESC_STRING) begin
					clamp_en = 1'b1;
					unique case (dindex)
						uep0_pkg::STR_LANGUAGE: begin
							clamp_src = uep0_pkg::SRC_LANGUAGE;
							clamp_len = {2'd0, language_len_q};
						end
						uep0_pkg::STR_MANUFACTURER: begin
							clamp_src = uep0_pkg::SRC_MANUFACTURER;
							clamp_len = {2'd0, manufacturer_len_q};
						end
						uep0_pkg::STR_PRODUCT: begin
							clamp_src = uep0_pkg::SRC_PRODUCT;
							clamp_len = {2'd0, product_len_q};
						end
						uep0_pkg::STR_SERIAL: begin
							clamp_src = uep0_pkg::SRC_SERIAL;
							clamp_len = {2'd0, serial_len_q};
						end
						default: begin
							// unknown string: empty reply
							clamp_src = uep0_pkg::SRC_NONE;
							clamp_len = 10'd0;
						end
					endcase
				end else if (dtype == uep0_pkg::DESC_REPORT) begin
					status_en = 1'b1;
				end else begin
					clamp_en = 1'b0;
				end
			end else if (kind == uep0_pkg::KIND_CLASS &&
			             code_s1 == uep0_pkg::REQ_GET_LINE_CODING) begin
				lc_en = 1'b1;
			end else if (kind == uep0_pkg::KIND_CLASS &&
			             code_s1 == uep0_pkg::REQ_SERIAL_STATE) begin
				status_en = 1'b1;
			end else begin
				status_en = 1'b0;
			end
		end else begin
			priority if (kind == uep0_pkg::KIND_STANDARD &&
			             code_s1 == uep0_pkg::REQ_SET_ADDRESS) begin
				addr_w    = 1'b1;
				status_en = 1'b1;
			end else if (kind == uep0_pkg::KIND_STANDARD &&
			             code_s1 == uep0_pkg::REQ_SET_CONFIGURATION) begin
				ep_w      = 1'b1;
				status_en = 1'b1;
			end else if (kind == uep0_pkg::KIND_CLASS &&
			             (code_s1 == uep0_pkg::REQ_SET_IDLE ||
			              code_s1 == uep0_pkg::REQ_SET_CONTROL_LINE_STATE)) begin
				status_en = 1'b1;
			end else begin
				status_en = 1'b0;
			end
		end
	end

	assign go     = clamp_en || status_en || lc_en;
	assign lc_len = (wlength_s1 > {13'd0, uep0_pkg::LINE_CODING_LEN}) ?
	                uep0_pkg::LINE_CODING_LEN : wlength_s1[2:0];

	// arm transfer state; a setup starts from cleared state
	always_comb begin
		arm_rem = remaining_q;
		arm_off = offset_q;
		arm_src = source_q;
		arm_zlp = zlp_pending_q;
		if (is_setup) begin
			arm_rem = '0;
			arm_off = '0;
			arm_src = uep0_pkg::SRC_NONE;
			arm_zlp = 1'b0;
			priority if (clamp_en) begin
				arm_src = clamp_src;
				if (wlength_s1 > {6'd0, clamp_len}) begin
					arm_rem = {6'd0, clamp_len};
					arm_zlp = ((clamp_len & {3'd0, pkt_mask}) == 10'd0);
				end else begin
					arm_rem = wlength_s1;
				end
			end else if (lc_en) begin
				arm_src = uep0_pkg::SRC_LINE_CODING;
				arm_rem = {13'd0, lc_len};
				arm_zlp = (({4'd0, lc_len} & pkt_mask) == 7'd0);
			end else if (status_en) begin
				arm_zlp = 1'b1;
			end else begin
				arm_zlp = 1'b0;
			end
		end
	end

	// send at most one packet
	always_comb begin
		nxt_rem  = arm_rem;
		nxt_off  = arm_off;
		nxt_zlp  = arm_zlp;
		send_len = '0;
		send_ok  = 1'b1;
		priority if (arm_rem > {9'd0, pkt_size}) begin
			send_len = pkt_size;
			nxt_rem  = arm_rem - {9'd0, pkt_size};
			nxt_off  = arm_off + {3'd0, pkt_size};
		end else if (arm_rem != '0) begin
			send_len = arm_rem[uep0_pkg::PKTLEN_W-1:0];
			nxt_rem  = '0;
		end else if (arm_zlp) begin
			nxt_zlp = 1'b0;
		end else begin
			send_ok = 1'b0;
		end
	end

	assign result = (is_setup ? go : 1'b1) && send_ok;

	// update transfer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q    <= '0;
			offset_q       <= '0;
			source_q       <= uep0_pkg::SRC_NONE;
			zlp_pending_q  <= 1'b0;
			config_value_q <= 8'd0;
		end else if (advance) begin
			remaining_q   <= nxt_rem;
			offset_q      <= nxt_off;
			source_q      <= arm_src;
			zlp_pending_q <= nxt_zlp;
			if (is_setup && ep_w) begin
				config_value_q <= wvalue_s1[7:0];
			end
		end
	end

	// load result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= advance && result;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result) begin
			src_q    <= arm_src;
			off_q    <= arm_off;
			len_q    <= send_len;
			addr_w_q <= is_setup && addr_w;
			addr_q   <= (is_setup && addr_w) ? wvalue_s1[6:0] : '0;
			ep_w_q   <= is_setup && ep_w;
			ep_en_q  <= is_setup && ep_w && (wvalue_s1[7:0] != 8'd0);
		end
	end

	assign out_valid        = out_valid_q;
	assign packet_source    = src_q;
	assign packet_offset    = off_q;
	assign packet_length    = len_q;
	assign address_write    = addr_w_q;
	assign new_address      = addr_q;
	assign endpoints_write  = ep_w_q;
	assign endpoints_enable = ep_en_q;

	// wIndex is carried but selects nothing; stored value shadows the enable
	logic unused_s1;
	assign unused_s1 = ^{windex_s1, config_value_q};

endmodule

// ===== hdl/uep0_checker.sv =====
module uep0_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [uep0_pkg::SRC_W-1:0]     packet_source,
	input logic [uep0_pkg::OFFSET_W-1:0]  packet_offset,
	input logic [uep0_pkg::PKTLEN_W-1:0]  packet_length,
	input logic                           address_write,
	input logic [uep0_pkg::ADDR_W-1:0]    new_address,
	input logic                           endpoints_write,
	input logic                           endpoints_enable
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(packet_source) &&
		$stable(packet_offset) && $stable(packet_length))
		else $error("stalled result changed");

	// packet never exceeds the largest control packet
	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> packet_length <= uep0_pkg::MAX_PACKET_BYTES)
		else $error("packet longer than max packet size");

	// SET_ADDRESS and SET_CONFIGURATION results are zero-length packets with no source
	a_status_zlp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (address_write || endpoints_write) |->
		packet_length == '0 && packet_source == uep0_pkg::SRC_NONE)
		else $error("status result carries data");

	// side outputs are quiet unless written
	a_side_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (address_write || new_address == '0) &&
		(endpoints_write || !endpoints_enable))
		else $error("side output set without write flag");

	// input waits only behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

endmodule

bind usb_ep0_control_responder uep0_checker u_uep0_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_stall         (in_stall),
	.out_valid        (out_valid),
	.out_stall        (out_stall),
	.packet_source    (packet_source),
	.packet_offset    (packet_offset),
	.packet_length    (packet_length),
	.address_write    (address_write),
	.new_address      (new_address),
	.endpoints_write  (endpoints_write),
	.endpoints_enable (endpoints_enable)
);

// ===== tb/usb_ep0_control_responder_tb.sv =====
module usb_ep0_control_responder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic       DIR_IN        = 1'b1;
	localparam logic       DIR_OUT       = 1'b0;
	localparam logic [1:0] KIND_VENDOR   = 2'd2;
	localparam int         HOLD_CYCLES   = 80;
	localparam int         SETTLE_CYCLES = 8;
	localparam int         PRINT_LIMIT   = 100;

	typedef struct {
		logic        op;
		logic [7:0]  rtype;
		logic [7:0]  code;
		logic [15:0] value;
		logic [15:0] index;
		logic [15:0] length;
	} request_t;

	typedef struct packed {
		logic [uep0_pkg::SRC_W-1:0]    src;
		logic [uep0_pkg::OFFSET_W-1:0] offset;
		logic [uep0_pkg::PKTLEN_W-1:0] len;
		logic                          addr_wr;
		logic [uep0_pkg::ADDR_W-1:0]   addr;
		logic                          ep_wr;
		logic                          ep_en;
	} reply_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [uep0_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [uep0_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = uep0_pkg::OP_SETUP;
	logic [7:0] request_type = '0;
	logic [7:0] request_code = '0;
	logic [uep0_pkg::WORD_W-1:0] request_value = '0;
	logic [uep0_pkg::WORD_W-1:0] request_index = '0;
	logic [uep0_pkg::WORD_W-1:0] request_length = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [uep0_pkg::SRC_W-1:0] packet_source;
	logic [uep0_pkg::OFFSET_W-1:0] packet_offset;
	logic [uep0_pkg::PKTLEN_W-1:0] packet_length;
	logic address_write;
	logic [uep0_pkg::ADDR_W-1:0] new_address;
	logic endpoints_write;
	logic endpoints_enable;

	// register copies, at their reset values
	logic [1:0] mps_code = 2'd1;
	logic [7:0] len_device = 8'd18;
	logic [9:0] len_config_total = 10'd67;
	logic [7:0] len_language = 8'd4;
	logic [7:0] len_manufacturer = 8'd18;
	logic [7:0] len_product = 8'd56;
	logic [7:0] len_serial = 8'd22;

	// transfer state of the control pipe
	logic [15:0] rem_bytes = '0;
	logic [uep0_pkg::OFFSET_W-1:0] next_offset = '0;
	logic [uep0_pkg::SRC_W-1:0] cur_source = uep0_pkg::SRC_NONE;
	logic zlp_armed = 1'b0;
	logic [7:0] config_value = '0;

	reply_t expected_packets[$];
	int mismatch_count = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_request = 1'b0;
	int hold_left = 0;

	usb_ep0_control_responder uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.request_type(request_type),
		.request_code(request_code),
		.request_value(request_value),
		.request_index(request_index),
		.request_length(request_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.packet_source(packet_source),
		.packet_offset(packet_offset),
		.packet_length(packet_length),
		.address_write(address_write),
		.new_address(new_address),
		.endpoints_write(endpoints_write),
		.endpoints_enable(endpoints_enable)
	);

	always #10 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("ERROR %0t: %s: got %0h, want %0h", $time, what, got, want);
	endtask

	function automatic int unsigned packet_bytes();
		return 8 << mps_code;
	endfunction

	// clamp a reply of full_len bytes to wLength, arm a ZLP on an exact packet multiple
	function automatic void arm_reply(input logic [uep0_pkg::SRC_W-1:0] src,
			input logic [9:0] full_len, input logic [15:0] wlen);
		cur_source = src;
		if (wlen > full_len) begin
			rem_bytes = 16'(full_len);
			zlp_armed = ((full_len & 10'(packet_bytes() - 1)) == '0);
		end else begin
			rem_bytes = wlen;
			zlp_armed = 1'b0;
		end
	endfunction

	function automatic void arm_status();
		cur_source = uep0_pkg::SRC_NONE;
		rem_bytes = '0;
		zlp_armed = 1'b1;
	endfunction

	// advance the control pipe by one transfer and queue the packet it sends, if any
	function automatic void predict_ep0_reply(input request_t r);
		reply_t rep;
		logic [1:0] kind;
		logic [15:0] lc_len;
		int unsigned psize;
		logic go;
		rep = '0;
		kind = r.rtype[6:5];
		psize = packet_bytes();
		if (r.op == uep0_pkg::OP_SETUP) begin
			// a new setup drops whatever transfer was in progress
			rem_bytes = '0;
			next_offset = '0;
			zlp_armed = 1'b0;
			cur_source = uep0_pkg::SRC_NONE;
			go = 1'b0;
			if (r.rtype[7] == DIR_IN) begin
				if (kind == uep0_pkg::KIND_STANDARD &&
						r.code == uep0_pkg::REQ_GET_DESCRIPTOR) begin
					go = 1'b1;
					case (r.value[15:8])
					uep0_pkg::DESC_DEVICE:
						arm_reply(uep0_pkg::SRC_DEVICE, 10'(len_device), r.length);
					uep0_pkg::DESC_CONFIG:
						arm_reply(uep0_pkg::SRC_CONFIG, len_config_total, r.length);
					uep0_pkg::DESC_STRING: begin
						case (r.value[7:0])
						uep0_pkg::STR_LANGUAGE:
							arm_reply(uep0_pkg::SRC_LANGUAGE, 10'(len_language), r.length);
						uep0_pkg::STR_MANUFACTURER:
							arm_reply(uep0_pkg::SRC_MANUFACTURER, 10'(len_manufacturer),
								r.length);
						uep0_pkg::STR_PRODUCT:
							arm_reply(uep0_pkg::SRC_PRODUCT, 10'(len_product), r.length);
						uep0_pkg::STR_SERIAL:
							arm_reply(uep0_pkg::SRC_SERIAL, 10'(len_serial), r.length);
						default: arm_reply(uep0_pkg::SRC_NONE, '0, r.length);
						endcase
					end
					uep0_pkg::DESC_REPORT: arm_status();
					default: go = 1'b0;
					endcase
				end else if (kind == uep0_pkg::KIND_CLASS &&
						r.code == uep0_pkg::REQ_GET_LINE_CODING) begin
					lc_len = (r.length > 16'(uep0_pkg::LINE_CODING_LEN)) ?
						16'(uep0_pkg::LINE_CODING_LEN) : r.length;
					cur_source = uep0_pkg::SRC_LINE_CODING;
					rem_bytes = lc_len;
					zlp_armed = ((lc_len & 16'(psize - 1)) == '0);
					go = 1'b1;
				end else if (kind == uep0_pkg::KIND_CLASS &&
						r.code == uep0_pkg::REQ_SERIAL_STATE) begin
					arm_status();
					go = 1'b1;
				end
			end else begin
				if (kind == uep0_pkg::KIND_STANDARD &&
						r.code == uep0_pkg::REQ_SET_ADDRESS) begin
					rep.addr_wr = 1'b1;
					rep.addr = r.value[uep0_pkg::ADDR_W-1:0];
					arm_status();
					go = 1'b1;
				end else if (kind == uep0_pkg::KIND_STANDARD &&
						r.code == uep0_pkg::REQ_SET_CONFIGURATION) begin
					config_value = r.value[7:0];
					rep.ep_wr = 1'b1;
					rep.ep_en = (config_value != '0);
					arm_status();
					go = 1'b1;
				end else if (kind == uep0_pkg::KIND_CLASS &&
						(r.code == uep0_pkg::REQ_SET_IDLE ||
						r.code == uep0_pkg::REQ_SET_CONTROL_LINE_STATE)) begin
					arm_status();
					go = 1'b1;
				end
			end
			if (!go)
				return;
		end
		// send at most one packet
		rep.src = cur_source;
		rep.offset = next_offset;
		if (rem_bytes > 16'(psize)) begin
			rep.len = psize[uep0_pkg::PKTLEN_W-1:0];
			rem_bytes = rem_bytes - psize[15:0];
			next_offset = next_offset + psize[uep0_pkg::OFFSET_W-1:0];
		end else if (rem_bytes != '0) begin
			rep.len = rem_bytes[uep0_pkg::PKTLEN_W-1:0];
			rem_bytes = '0;
		end else if (zlp_armed) begin
			rep.len = '0;
			zlp_armed = 1'b0;
		end else begin
			return;
		end
		expected_packets.push_back(rep);
	endfunction

	// present one request and hold it until the block takes it
	task automatic send_request(input request_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= r.op;
		request_type <= r.rtype;
		request_code <= r.code;
		request_value <= r.value;
		request_index <= r.index;
		request_length <= r.length;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_ep0_reply(r);
		@(negedge clk);
	endtask

	// drop valid and wait until every packet is out and the pipe is empty
	task automatic settle_block();
		in_valid <= 1'b0;
		while (expected_packets.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [uep0_pkg::CFG_IDX_W-1:0] idx,
			input logic [uep0_pkg::CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		case (idx)
		uep0_pkg::REG_MAX_PACKET_CODE:  mps_code = data[1:0];
		uep0_pkg::REG_DEVICE_LEN:       len_device = data[7:0];
		uep0_pkg::REG_CONFIG_TOTAL_LEN: len_config_total = data;
		uep0_pkg::REG_LANGUAGE_LEN:     len_language = data[7:0];
		uep0_pkg::REG_MANUFACTURER_LEN: len_manufacturer = data[7:0];
		uep0_pkg::REG_PRODUCT_LEN:      len_product = data[7:0];
		uep0_pkg::REG_SERIAL_LEN:       len_serial = data[7:0];
		default: ;
		endcase
	endtask

	// unused upper data bits carry noise
	task automatic apply_config(input logic [1:0] code, input int unsigned dev,
			input int unsigned cfg_total, input int unsigned lang, input int unsigned manuf,
			input int unsigned prod, input int unsigned ser);
		write_reg(uep0_pkg::REG_MAX_PACKET_CODE, {8'($urandom), code});
		write_reg(uep0_pkg::REG_DEVICE_LEN, {2'($urandom), 8'(dev)});
		write_reg(uep0_pkg::REG_CONFIG_TOTAL_LEN, 10'(cfg_total));
		write_reg(uep0_pkg::REG_LANGUAGE_LEN, {2'($urandom), 8'(lang)});
		write_reg(uep0_pkg::REG_MANUFACTURER_LEN, {2'($urandom), 8'(manuf)});
		write_reg(uep0_pkg::REG_PRODUCT_LEN, {2'($urandom), 8'(prod)});
		write_reg(uep0_pkg::REG_SERIAL_LEN, {2'($urandom), 8'(ser)});
	endtask

	function automatic request_t make_setup(input logic dir, input logic [1:0] kind,
			input logic [7:0] code, input logic [15:0] value, input logic [15:0] index,
			input logic [15:0] length);
		request_t r;
		r.op = uep0_pkg::OP_SETUP;
		r.rtype = {dir, kind, 5'($urandom_range(0, 31))};
		r.code = code;
		r.value = value;
		r.index = index;
		r.length = length;
		return r;
	endfunction

	// IN-complete event; the other fields are ignored, so fill them with noise
	function automatic request_t in_event();
		request_t r;
		r.op = uep0_pkg::OP_IN_DONE;
		r.rtype = 8'($urandom);
		r.code = 8'($urandom);
		r.value = 16'($urandom);
		r.index = 16'($urandom);
		r.length = 16'($urandom);
		return r;
	endfunction

	// wLength around the interesting points of a reply of full bytes
	function automatic logic [15:0] pick_length(input logic [9:0] full);
		case ($urandom_range(0, 7))
		0: return '0;
		1: return 16'hFFFF;
		2: return 16'(full);
		3: return 16'(full) + 16'd1;
		4: return (full == '0) ? '0 : 16'(full) - 16'd1;
		5, 6: return 16'($urandom_range(0, 4 * packet_bytes()));
		default: return 16'($urandom);
		endcase
	endfunction

	function automatic int unsigned pick_desc_len(input int unsigned max_len,
			input int unsigned psz);
		if ($urandom_range(0, 1))
			return $urandom_range(0, max_len);
		return $urandom_range(0, max_len / psz) * psz;
	endfunction

	// mostly well-formed setups with random content, some noise
	function automatic request_t random_request();
		request_t r;
		logic [7:0] dtype;
		logic [7:0] sidx;
		logic [9:0] full;
		int unsigned pick;
		r = make_setup(DIR_OUT, uep0_pkg::KIND_STANDARD, '0, 16'($urandom), 16'($urandom),
			16'($urandom));
		pick = $urandom_range(0, 19);
		if (pick < 8) begin
			case ($urandom_range(0, 5))
			0: dtype = uep0_pkg::DESC_DEVICE;
			1: dtype = uep0_pkg::DESC_CONFIG;
			2, 3: dtype = uep0_pkg::DESC_STRING;
			4: dtype = uep0_pkg::DESC_REPORT;
			default: dtype = 8'($urandom);
			endcase
			sidx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
			full = '0;
			if (dtype == uep0_pkg::DESC_DEVICE)
				full = 10'(len_device);
			else if (dtype == uep0_pkg::DESC_CONFIG)
				full = len_config_total;
			else if (dtype == uep0_pkg::DESC_STRING)
				case (sidx)
				uep0_pkg::STR_LANGUAGE: full = 10'(len_language);
				uep0_pkg::STR_MANUFACTURER: full = 10'(len_manufacturer);
				uep0_pkg::STR_PRODUCT: full = 10'(len_product);
				uep0_pkg::STR_SERIAL: full = 10'(len_serial);
				default: full = '0;
				endcase
			r = make_setup(DIR_IN, uep0_pkg::KIND_STANDARD, uep0_pkg::REQ_GET_DESCRIPTOR,
				{dtype, sidx}, r.index, pick_length(full));
		end else if (pick < 10) begin
			r = make_setup(DIR_IN, uep0_pkg::KIND_CLASS, uep0_pkg::REQ_GET_LINE_CODING,
				r.value, r.index, pick_length(10'(uep0_pkg::LINE_CODING_LEN)));
		end else if (pick == 10) begin
			r = make_setup(DIR_IN, uep0_pkg::KIND_CLASS, uep0_pkg::REQ_SERIAL_STATE,
				r.value, r.index, r.length);
		end else if (pick < 13) begin
			r = make_setup(DIR_OUT, uep0_pkg::KIND_STANDARD, uep0_pkg::REQ_SET_ADDRESS,
				r.value, r.index, r.length);
		end else if (pick < 15) begin
			if ($urandom_range(0, 1))
				r.value[7:0] = '0;
			r = make_setup(DIR_OUT, uep0_pkg::KIND_STANDARD,
				uep0_pkg::REQ_SET_CONFIGURATION, r.value, r.index, r.length);
		end else if (pick < 17) begin
			r = make_setup(DIR_OUT, uep0_pkg::KIND_CLASS,
				$urandom_range(0, 1) ? uep0_pkg::REQ_SET_IDLE :
				uep0_pkg::REQ_SET_CONTROL_LINE_STATE,
				r.value, r.index, r.length);
		end else begin
			// noise: any type, known or random code, either op
			r.op = 1'($urandom);
			r.rtype = 8'($urandom);
			case ($urandom_range(0, 3))
			0: r.code = uep0_pkg::REQ_GET_DESCRIPTOR;
			1: r.code = uep0_pkg::REQ_SET_ADDRESS;
			2: r.code = uep0_pkg::REQ_GET_LINE_CODING;
			default: r.code = 8'($urandom);
			endcase
		end
		return r;
	endfunction

	// each setup is followed by a run of IN-complete events, now and then a long one
	task automatic run_transfers(input int n);
		request_t r;
		int sent;
		int k;
		sent = 0;
		while (sent < n) begin
			r = random_request();
			send_request(r);
			sent++;
			if (r.op == uep0_pkg::OP_SETUP) begin
				k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 140) : $urandom_range(0, 8);
				for (int j = 0; j < k; j++) begin
					send_request(in_event());
					sent++;
				end
			end
		end
	endtask

	// default registers, 16-byte packets
	task automatic test_directed_requests();
		send_request(make_setup(DIR_IN, uep0_pkg::KIND_STANDARD, uep0_pkg::REQ_GET_DESCRIPTOR,
			{uep0_pkg::DESC_DEVICE, 8'h00}, 16'h0000, 16'hFFFF));
		send_request(in_event());
		send_request(in_event());
		send_request(make_setup(DIR_IN, uep0_pkg::KIND_STANDARD, uep0_pkg::REQ_GET_DESCRIPTOR,
			{uep0_pkg::DESC_DEVICE, 8'h00}, 16'hFFFF, 16'h0000));
		send_request(make_setup(DIR_IN, uep0_pkg::KIND_STANDARD, uep0_pkg::REQ_GET_DESCRIPTOR,
			{uep0_pkg::DESC_CONFIG, 8'h00}, 16'h0000, 16'd40));
		send_request(in_event());
		send_request(in_event());
		send_request(make_setup(DIR_IN, uep0_pkg::KIND_STANDARD, uep0_pkg::REQ_GET_DESCRIPTOR,
			{uep0_pkg::DESC_STRING, uep0_pkg::STR_LANGUAGE}, 16'h0000, 16'd255));
		send_request(make_setup(DIR_IN, uep0_pkg::KIND_STANDARD, uep0_pkg::REQ_GET_DESCRIPTOR,
			{uep0_pkg::DESC_STRING, uep0_pkg::STR_MANUFACTURER}, 16'h0409, 16'd18));
		send_request(in_event());
		send_request(make_setup(DIR_IN, uep0_pkg::KIND_STANDARD, uep0_pkg::REQ_GET_DESCRIPTOR,
			{uep0_pkg::DESC_STRING, uep0_pkg::STR_PRODUCT}, 16'h0409, 16'd2));
		// serial string cut short by the next setup
		send_request(make_setup(DIR_IN, uep0_pkg::KIND_STANDARD, uep0_pkg::REQ_GET_DESCRIPTOR,
			{uep0_pkg::DESC_STRING, uep0_pkg::STR_SERIAL}, 16'h0409, 16'h7FFF));
		// unknown string index: ZLP when wLength is nonzero, nothing otherwise
		send_request(make_setup(DIR_IN, uep0_pkg::KIND_STANDARD, uep0_pkg::REQ_GET_DESCRIPTOR,
			{uep0_pkg::DESC_STRING, 8'hFF}, 16'h0409, 16'd1));
		send_request(make_setup(DIR_IN, uep0_pkg::KIND_STANDARD, uep0_pkg::REQ_GET_DESCRIPTOR,
			{uep0_pkg::DESC_STRING, 8'h04}, 16'h0409, 16'd0));
		send_request(make_setup(DIR_IN, uep0_pkg::KIND_STANDARD, uep0_pkg::REQ_GET_DESCRIPTOR,
			{uep0_pkg::DESC_REPORT, 8'h00}, 16'h0000, 16'hFFFF));
		send_request(make_setup(DIR_IN, uep0_pkg::KIND_STANDARD, uep0_pkg::REQ_GET_DESCRIPTOR,
			{8'h05, 8'h00}, 16'h0000, 16'hFFFF));
		// line coding with zero wLength still sends a ZLP
		send_request(make_setup(DIR_IN, uep0_pkg::KIND_CLASS, uep0_pkg::REQ_GET_LINE_CODING,
			16'h0000, 16'h0000, 16'd0));
		send_request(make_setup(DIR_IN, uep0_pkg::KIND_CLASS, uep0_pkg::REQ_GET_LINE_CODING,
			16'h0000, 16'h0000, 16'hFFFF));
		send_request(make_setup(DIR_IN, uep0_pkg::KIND_CLASS, uep0_pkg::REQ_SERIAL_STATE,
			16'h0000, 16'h0000, 16'd2));
		send_request(make_setup(DIR_OUT, uep0_pkg::KIND_STANDARD, uep0_pkg::REQ_SET_ADDRESS,
			16'hFFFF, 16'hFFFF, 16'h0000));
		send_request(make_setup(DIR_OUT, uep0_pkg::KIND_STANDARD,
			uep0_pkg::REQ_SET_CONFIGURATION, 16'h00FF, 16'h0000, 16'h0000));
		send_request(make_setup(DIR_OUT, uep0_pkg::KIND_STANDARD,
			uep0_pkg::REQ_SET_CONFIGURATION, 16'hFF00, 16'h0000, 16'h0000));
		send_request(make_setup(DIR_OUT, uep0_pkg::KIND_CLASS, uep0_pkg::REQ_SET_IDLE,
			16'h0000, 16'h0000, 16'h0000));
		send_request(make_setup(DIR_OUT, uep0_pkg::KIND_CLASS,
			uep0_pkg::REQ_SET_CONTROL_LINE_STATE, 16'h0003, 16'h0000, 16'h0000));
		// vendor request: ignored
		send_request(make_setup(DIR_IN, KIND_VENDOR, uep0_pkg::REQ_GET_DESCRIPTOR,
			{uep0_pkg::DESC_DEVICE, 8'h00}, 16'h0000, 16'hFFFF));
		send_request(in_event());
	endtask

	// sweep packet sizes and descriptor lengths, including extremes and exact multiples
	task automatic test_random_configs();
		logic [1:0] code;
		int unsigned psz;
		for (int ph = 0; ph < 9; ph++) begin
			settle_block();
			if (ph < 3) begin
				send_idle_pct = 7;
				recv_stall_pct = 60;
			end else if (ph < 6) begin
				send_idle_pct = 60;
				recv_stall_pct = 7;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			case (ph)
			0: apply_config(2'd0, 255, 1023, 255, 255, 255, 255);
			1: apply_config(2'd3, 255, 1023, 255, 255, 255, 255);
			2: apply_config(2'd0, 0, 0, 0, 0, 0, 0);
			3: apply_config(2'd3, 64, 512, 0, 128, 192, 64);
			4: apply_config(2'd2, 32, 96, 0, 224, 64, 160);
			default: begin
				code = 2'($urandom_range(0, 3));
				psz = 8 << code;
				apply_config(code, pick_desc_len(255, psz), pick_desc_len(1023, psz),
					pick_desc_len(255, psz), pick_desc_len(255, psz),
					pick_desc_len(255, psz), pick_desc_len(255, psz));
			end
			endcase
			run_transfers(140);
		end
	endtask

	// receiver holds off for a long stretch while requests keep coming
	task automatic test_output_hold();
		settle_block();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b1;
		repeat (40) send_request(random_request());
	endtask

	// receiver stall: random, or a counted hold-off on request
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// check each packet transfer against the oldest prediction
	always @(posedge clk) begin : check_packets
		reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_packets.size() == 0) begin
				report_mismatch("packet with none expected, length", int'(packet_length), 0);
			end else begin
				want = expected_packets.pop_front();
				if (packet_source !== want.src)
					report_mismatch("packet_source", int'(packet_source), int'(want.src));
				if (packet_offset !== want.offset)
					report_mismatch("packet_offset", int'(packet_offset), int'(want.offset));
				if (packet_length !== want.len)
					report_mismatch("packet_length", int'(packet_length), int'(want.len));
				if (address_write !== want.addr_wr)
					report_mismatch("address_write", int'(address_write), int'(want.addr_wr));
				if (new_address !== want.addr)
					report_mismatch("new_address", int'(new_address), int'(want.addr));
				if (endpoints_write !== want.ep_wr)
					report_mismatch("endpoints_write", int'(endpoints_write), int'(want.ep_wr));
				if (endpoints_enable !== want.ep_en)
					report_mismatch("endpoints_enable", int'(endpoints_enable),
						int'(want.ep_en));
			end
		end
	end

	initial begin
		#10_000_000;
		$display("usb_ep0_control_responder: mismatch");
		$finish;
	end

	initial begin : main_sequence
		int waited;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_idle_pct = 7;
		recv_stall_pct = 60;
		test_directed_requests();
		test_random_configs();
		test_output_hold();

		// drain and watch for stray packets
		in_valid <= 1'b0;
		waited = 0;
		while (expected_packets.size() != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		if (expected_packets.size() != 0)
			report_mismatch("packets never delivered", 0, expected_packets.size());
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("usb_ep0_control_responder: match");
		else
			$display("usb_ep0_control_responder: mismatch");
		$finish;
	end

endmodule
